// File: hdl/mpl_pkg.sv
// Shared types and codes of the mesh peering link block.
// No dependencies; the top level, mpl_ctrl and mpl_dpath import this package.
`timescale 1ns / 1ps
`default_nettype none
package mpl_pkg;

  localparam int PeerEntriesDef = 16;

  // link states
  localparam logic [2:0] ST_LISTEN   = 3'd0;
  localparam logic [2:0] ST_OPN_SNT  = 3'd1;
  localparam logic [2:0] ST_OPN_RCVD = 3'd2;
  localparam logic [2:0] ST_CNF_RCVD = 3'd3;
  localparam logic [2:0] ST_ESTAB    = 3'd4;
  localparam logic [2:0] ST_HOLDING  = 3'd5;
  localparam logic [2:0] ST_BLOCKED  = 3'd6;

  // events
  localparam logic [3:0] EV_NONE     = 4'd0;
  localparam logic [3:0] EV_OPN_ACPT = 4'd1;
  localparam logic [3:0] EV_OPN_RJCT = 4'd2;
  localparam logic [3:0] EV_OPN_IGNR = 4'd3;
  localparam logic [3:0] EV_CNF_ACPT = 4'd4;
  localparam logic [3:0] EV_CNF_RJCT = 4'd5;
  localparam logic [3:0] EV_CNF_IGNR = 4'd6;
  localparam logic [3:0] EV_CLS_ACPT = 4'd7;
  localparam logic [3:0] EV_CLS_IGNR = 4'd8;

  // frame actions
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_OPEN    = 2'd1;
  localparam logic [1:0] ACT_CONFIRM = 2'd2;
  localparam logic [1:0] ACT_CLOSE   = 2'd3;

  // operations
  localparam logic OP_FRAME  = 1'b0;
  localparam logic OP_BEACON = 1'b1;

  // one peer table entry as stored in the RAM
  typedef struct packed {
    logic [47:0] addr;
    logic [2:0]  link_state;
    logic [15:0] local_id;
    logic [15:0] peer_id;
    logic        close_reason;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_proc;
    logic id_proc;
    logic eval;
    logic apply;
    logic out_sel;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_id;
    logic two_tx;
  } status_t;

endpackage
`default_nettype wire

// File: hdl/mpl_if.sv
// Valid/ready channel interfaces for input and result words.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface mpl_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [1:0]  frame_action;
  logic [47:0] peer_addr;
  logic [15:0] rx_peer_link_id;
  logic [15:0] rx_echoed_link_id;
  logic        profile_match;
  logic        dest_multicast;
  logic [15:0] random_link_id;
  modport source (output valid, operation, frame_action, peer_addr, rx_peer_link_id,
                  rx_echoed_link_id, profile_match, dest_multicast, random_link_id,
                  input ready);
  modport sink (input valid, operation, frame_action, peer_addr, rx_peer_link_id,
                rx_echoed_link_id, profile_match, dest_multicast, random_link_id,
                output ready);
endinterface

interface mpl_out_if;
  logic        valid;
  logic        ready;
  logic        tx_valid;
  logic [1:0]  tx_action;
  logic [47:0] tx_dest;
  logic [15:0] tx_local_link_id;
  logic [15:0] tx_peer_link_id;
  logic [15:0] tx_sequence;
  logic [3:0]  event_code;
  logic [2:0]  link_state_out;
  logic        table_full;
  logic        last;
  modport source (output valid, tx_valid, tx_action, tx_dest, tx_local_link_id,
                  tx_peer_link_id, tx_sequence, event_code, link_state_out, table_full,
                  last, input ready);
  modport sink (input valid, tx_valid, tx_action, tx_dest, tx_local_link_id,
                tx_peer_link_id, tx_sequence, event_code, link_state_out, table_full,
                last, output ready);
endinterface
`default_nettype wire

// File: hdl/mesh_peering_link_fsm.sv
// Top level of the mesh peering link block: sequencer plus datapath.
// Depends on mpl_pkg, mpl_if, mpl_ctrl, mpl_dpath (and mpl_ram below it).
//
//   channel  dir  word
//   rx       in   received peering frame or neighbour beacon
//   tx       out  one to two result words, last marks the final one
//
// Each item runs a lookup scan of the table RAM (one entry per cycle), then,
// when a fresh link id is needed, an id scan of the same kind, and then
// delivers its one or two result words.
// Synchronous reset clears the used bits and the frame sequence counter.
// A stalled result word holds; no new item is taken until all words leave.
`timescale 1ns / 1ps
`default_nettype none
module mesh_peering_link_fsm import mpl_pkg::*; #(
  parameter int PEER_ENTRIES = PeerEntriesDef
) (
  input wire logic  clk,
  input wire logic  rst,
  mpl_in_if.sink    rx,
  mpl_out_if.source tx
);

  localparam int IDXW = (PEER_ENTRIES > 1) ? $clog2(PEER_ENTRIES) : 1;

  cmd_t            cmd;
  status_t         status;
  logic [IDXW-1:0] raddr;

  mpl_ctrl #(.PEER_ENTRIES(PEER_ENTRIES)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx.valid),
    .in_ready  (rx.ready),
    .out_valid (tx.valid),
    .out_ready (tx.ready),
    .status    (status),
    .cmd       (cmd),
    .raddr     (raddr)
  );

  mpl_dpath #(.PEER_ENTRIES(PEER_ENTRIES)) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .raddr  (raddr),
    .status (status),
    .rx     (rx),
    .tx     (tx)
  );

endmodule
`default_nettype wire

// File: hdl/mpl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hdl/mpl_ctrl.sv
// Sequencer of the peering block: scan, evaluate, id scan, apply, deliver.
// Depends on mpl_pkg only.
`timescale 1ns / 1ps
`default_nettype none
module mpl_ctrl import mpl_pkg::*; #(
  parameter int PEER_ENTRIES = PeerEntriesDef,
  localparam int IDXW = (PEER_ENTRIES > 1) ? $clog2(PEER_ENTRIES) : 1,
  localparam int CW = $clog2(PEER_ENTRIES + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire status_t         status,
  output cmd_t                 cmd,
  output logic      [IDXW-1:0] raddr
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_EVAL   = 7'b0000100,
    S_IDSCAN = 7'b0001000,
    S_APPLY  = 7'b0010000,
    S_OUT0   = 7'b0100000,
    S_OUT1   = 7'b1000000
  } state_t;

  localparam logic [CW-1:0] LastCnt = CW'(PEER_ENTRIES);

  state_t        state, state_next;
  logic [CW-1:0] cnt, cnt_next;

  // next state and counter
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        cnt_next = cnt + 1'b1;
        if (cnt == LastCnt) state_next = S_EVAL;
      end
      S_EVAL: begin
        cnt_next = '0;
        state_next = status.need_id ? S_IDSCAN : S_APPLY;
      end
      S_IDSCAN: begin
        cnt_next = cnt + 1'b1;
        if (cnt == LastCnt) state_next = S_APPLY;
      end
      S_APPLY: state_next = S_OUT0;
      S_OUT0: begin
        if (out_ready) state_next = status.two_tx ? S_OUT1 : S_IDLE;
      end
      S_OUT1: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // drive handshake and datapath commands
  always_comb begin
    in_ready      = (state == S_IDLE);
    out_valid     = (state == S_OUT0) || (state == S_OUT1);
    cmd.load      = in_valid && (state == S_IDLE);
    cmd.scan_proc = (state == S_SCAN) && (cnt != '0);
    cmd.id_proc   = (state == S_IDSCAN) && (cnt != '0);
    cmd.eval      = (state == S_EVAL);
    cmd.apply     = (state == S_APPLY);
    cmd.out_sel   = (state == S_OUT1);
    raddr         = cnt[IDXW-1:0];
  end

endmodule
`default_nettype wire

// File: hdl/mpl_dpath.sv
// Datapath: peer table RAM, used bits, event classification and link update.
// Depends on mpl_pkg, mpl_ram and the channel interfaces in mpl_if.
`timescale 1ns / 1ps
`default_nettype none
module mpl_dpath import mpl_pkg::*; #(
  parameter int PEER_ENTRIES = PeerEntriesDef,
  localparam int IDXW = (PEER_ENTRIES > 1) ? $clog2(PEER_ENTRIES) : 1,
  localparam int ZW = $clog2(PEER_ENTRIES + 2)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cmd_t            cmd,
  input  wire logic [IDXW-1:0] raddr,
  output status_t              status,
  mpl_in_if.sink               rx,
  mpl_out_if.source            tx
);

  // latched input word
  logic        op, match, mcast;
  logic [1:0]  fa;
  logic [47:0] addr;
  logic [15:0] plid, echo, rnd;

  logic [PEER_ENTRIES-1:0] used;
  logic [15:0]             seq;
  logic                    full, hit, ffound, exists;
  logic [IDXW-1:0]         hidx, fidx, ridx;
  entry_t                  w, rdata, w_upd;
  logic [3:0]              ev;
  logic [PEER_ENTRIES:0]   mask;
  logic                    two_tx, one_tx;
  logic [1:0]              act0;
  logic [15:0]             lid0, pid0, lid1, pid1, seq0, seq1;
  logic [2:0]              state_out;

  logic [$bits(entry_t)-1:0] rdata_raw;
  logic                      ram_we;

  mpl_ram #(.WIDTH($bits(entry_t)), .DEPTH(PEER_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (hidx),
    .wdata (w_upd),
    .raddr (raddr),
    .rdata (rdata_raw)
  );
  assign rdata = entry_t'(rdata_raw);

  // classify the received frame
  logic       op0_valid;
  logic [15:0] llid;
  logic [3:0] ev_c;
  always_comb begin
    op0_valid = (op == OP_FRAME) && !mcast && (fa != 2'd0);
    llid = (fa == ACT_CONFIRM) ? echo : 16'd0;
    if (!match && !hit) ev_c = EV_OPN_RJCT;
    else if (!hit) ev_c = (fa != ACT_OPEN || full) ? EV_NONE : EV_OPN_ACPT;
    else if (w.link_state == ST_BLOCKED) ev_c = EV_NONE;
    else if (fa == ACT_OPEN) begin
      if (!match) ev_c = EV_OPN_RJCT;
      else if (full || (w.peer_id != 16'd0 && w.peer_id != plid)) ev_c = EV_OPN_IGNR;
      else ev_c = EV_OPN_ACPT;
    end else if (fa == ACT_CONFIRM) begin
      if (!match) ev_c = EV_CNF_RJCT;
      else if (full || w.local_id != llid ||
               (w.peer_id != 16'd0 && w.peer_id != plid)) ev_c = EV_CNF_IGNR;
      else ev_c = EV_CNF_ACPT;
    end else if (w.link_state == ST_ESTAB) ev_c = EV_CLS_ACPT;
    else if (w.peer_id != plid) ev_c = EV_CLS_IGNR;
    else if (w.local_id != 16'd0 && w.local_id != llid) ev_c = EV_CLS_IGNR;
    else ev_c = EV_CLS_ACPT;
    if (!op0_valid) ev_c = EV_NONE;
  end

  // allocate and take the peer id during evaluation
  logic   exists_c, alloc_c, need_id_c;
  entry_t w_eval;
  always_comb begin
    if (op == OP_BEACON) exists_c = hit || !full;
    else exists_c = hit || (ev_c == EV_OPN_ACPT);
    alloc_c = exists_c && !hit;
    w_eval = w;
    if (alloc_c) begin
      w_eval = '{addr: addr, link_state: ST_LISTEN, local_id: 16'd0,
                 peer_id: 16'd0, close_reason: 1'b0};
    end
    if (ev_c == EV_OPN_ACPT) w_eval.peer_id = plid;
    if (ev_c == EV_CNF_ACPT && w_eval.peer_id == 16'd0) w_eval.peer_id = plid;
    need_id_c = exists_c && (w_eval.link_state == ST_LISTEN) &&
                ((op == OP_BEACON) || (ev_c == EV_OPN_ACPT));
  end
  assign status.need_id = need_id_c;
  assign status.two_tx  = two_tx;

  // first free id at or above the candidate
  logic [ZW-1:0] zpos;
  logic [15:0]   new_id;
  always_comb begin
    zpos = ZW'(PEER_ENTRIES + 1);
    for (int j = PEER_ENTRIES; j >= 0; j--) begin
      if (!mask[j]) zpos = ZW'(j);
    end
    new_id = rnd + 16'(zpos);
  end

  // id scan offset of the entry being read
  logic        self_k, inuse_k;
  logic [15:0] dist_k;
  always_comb begin
    self_k  = exists && (ridx == hidx);
    inuse_k = self_k || used[ridx];
    dist_k  = (self_k ? w.local_id : rdata.local_id) - rnd;
  end

  // link state machine step
  logic [1:0] act_c;
  logic       rej_or_cls;
  logic       two_c;
  always_comb begin
    w_upd = w;
    act_c = ACT_NONE;
    rej_or_cls = (ev == EV_OPN_RJCT) || (ev == EV_CNF_RJCT) || (ev == EV_CLS_ACPT);
    if (op == OP_BEACON) begin
      if (exists && w.link_state == ST_LISTEN) begin
        w_upd.local_id = new_id;
        w_upd.link_state = ST_OPN_SNT;
        act_c = ACT_OPEN;
      end
    end else if (!exists) begin
      if (ev == EV_OPN_RJCT) act_c = ACT_CLOSE;
    end else begin
      case (w.link_state)
        ST_LISTEN: begin
          if (ev == EV_CLS_ACPT) begin
            w_upd.link_state = ST_LISTEN;
            w_upd.local_id = 16'd0;
            w_upd.peer_id = 16'd0;
            w_upd.close_reason = 1'b0;
          end else if (ev == EV_OPN_ACPT) begin
            w_upd.link_state = ST_OPN_RCVD;
            w_upd.local_id = new_id;
            act_c = ACT_OPEN;
          end
        end
        ST_OPN_SNT, ST_OPN_RCVD, ST_CNF_RCVD: begin
          if (rej_or_cls) begin
            w_upd.link_state = ST_HOLDING;
            w_upd.close_reason = (ev != EV_CLS_ACPT);
            act_c = ACT_CLOSE;
          end else if (ev == EV_OPN_ACPT) begin
            act_c = ACT_CONFIRM;
            if (w.link_state == ST_OPN_SNT) w_upd.link_state = ST_OPN_RCVD;
            if (w.link_state == ST_CNF_RCVD) w_upd.link_state = ST_ESTAB;
          end else if (ev == EV_CNF_ACPT) begin
            if (w.link_state == ST_OPN_SNT) w_upd.link_state = ST_CNF_RCVD;
            if (w.link_state == ST_OPN_RCVD) w_upd.link_state = ST_ESTAB;
          end
        end
        ST_ESTAB: begin
          if (ev == EV_CLS_ACPT) begin
            w_upd.link_state = ST_HOLDING;
            w_upd.close_reason = 1'b0;
            act_c = ACT_CLOSE;
          end else if (ev == EV_OPN_ACPT) begin
            act_c = ACT_CONFIRM;
          end
        end
        ST_HOLDING: begin
          if (ev == EV_CLS_ACPT) begin
            w_upd.link_state = ST_LISTEN;
            w_upd.local_id = 16'd0;
            w_upd.peer_id = 16'd0;
            w_upd.close_reason = 1'b0;
          end else if (ev == EV_OPN_ACPT || ev == EV_CNF_ACPT ||
                       ev == EV_OPN_RJCT || ev == EV_CNF_RJCT) begin
            act_c = ACT_CLOSE;
          end
        end
        default: ;
      endcase
    end
    // an open answering a frame is followed by a confirm; a beacon open is not
    two_c = (act_c == ACT_OPEN) && (op == OP_FRAME);
  end
  assign ram_we = cmd.apply && exists;

  // used bits and sequence counter
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      seq  <= '0;
    end else if (cmd.apply) begin
      if (exists) used[hidx] <= 1'b1;
      if (two_c) seq <= seq + 16'd2;
      else if (act_c != ACT_NONE) seq <= seq + 16'd1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ridx <= raddr;
    if (cmd.load) begin
      op     <= rx.operation;
      fa     <= rx.frame_action;
      addr   <= rx.peer_addr;
      plid   <= rx.rx_peer_link_id;
      echo   <= rx.rx_echoed_link_id;
      match  <= rx.profile_match;
      mcast  <= rx.dest_multicast;
      rnd    <= rx.random_link_id;
      full   <= &used;
      hit    <= 1'b0;
      ffound <= 1'b0;
    end
    // lookup and free search
    if (cmd.scan_proc) begin
      if (!hit && used[ridx] && rdata.addr == addr) begin
        hit  <= 1'b1;
        hidx <= ridx;
        w    <= rdata;
      end
      if (!ffound && !used[ridx]) begin
        ffound <= 1'b1;
        fidx   <= ridx;
      end
    end
    if (cmd.eval) begin
      ev     <= ev_c;
      exists <= exists_c;
      w      <= w_eval;
      mask   <= '0;
      if (alloc_c) hidx <= fidx;
    end
    // mark ids in use near the candidate
    if (cmd.id_proc && inuse_k) begin
      for (int j = 0; j <= PEER_ENTRIES; j++) begin
        if (dist_k == 16'(j)) mask[j] <= 1'b1;
      end
    end
    if (cmd.apply) begin
      w         <= w_upd;
      one_tx    <= (act_c != ACT_NONE);
      two_tx    <= two_c;
      act0      <= act_c;
      lid0      <= (op == OP_FRAME && !exists) ? 16'd0 : w_upd.local_id;
      pid0      <= (act_c == ACT_CONFIRM) ? w_upd.peer_id : 16'd0;
      lid1      <= w_upd.local_id;
      pid1      <= w_upd.peer_id;
      seq0      <= seq + 16'd1;
      seq1      <= seq + 16'd2;
      state_out <= exists ? w_upd.link_state : ST_LISTEN;
    end
  end

  // result word
  always_comb begin
    tx.tx_valid         = cmd.out_sel ? 1'b1 : one_tx;
    tx.tx_action        = cmd.out_sel ? ACT_CONFIRM : act0;
    tx.tx_dest          = (cmd.out_sel || one_tx) ? addr : 48'd0;
    tx.tx_local_link_id = cmd.out_sel ? lid1 : (one_tx ? lid0 : 16'd0);
    tx.tx_peer_link_id  = cmd.out_sel ? pid1 : pid0;
    tx.tx_sequence      = cmd.out_sel ? seq1 : (one_tx ? seq0 : 16'd0);
    tx.event_code       = ev;
    tx.link_state_out   = state_out;
    tx.table_full       = full;
    tx.last             = cmd.out_sel || !two_tx;
  end

endmodule
`default_nettype wire
